// ===== sv/htlp_pkg.sv =====
// package for the linear-probing hash table: field widths, codes, fsm state
// and the command/status structs between controller and datapath
// no dependencies
package htlp_pkg;

    // field widths of the stream beats and the config register
    localparam int CFG_W     = 11;
    localparam int KEY_W     = 30;
    localparam int PAYLOAD_W = 32;
    localparam int STATUS_W  = 2;
    localparam int SLOT_W    = 10;
    localparam int PROBES_W  = 11;

    // packed beat widths, rounded up to whole bytes
    localparam int S_TDATA_W = 64;
    localparam int M_FIELDS_W = SLOT_W + PAYLOAD_W + PROBES_W;
    localparam int M_TDATA_W = 56;
    localparam int M_PAD_W   = M_TDATA_W - M_FIELDS_W;

    // one table entry: occupied flag, key, payload
    localparam int ENTRY_W = 1 + KEY_W + PAYLOAD_W;

    // defaults
    localparam int              TABLE_DEPTH_DEFAULT = 1024;
    localparam logic [CFG_W-1:0] MODULUS_RESET      = 11'd631;

    // remainder unit: two key bits per cycle
    localparam int DIV_BITS  = 2;
    localparam int DIV_STEPS = KEY_W / DIV_BITS;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_SEARCH = 1'b1
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_INSERTED  = 2'd0,
        STAT_FOUND     = 2'd1,
        STAT_NOT_FOUND = 2'd2,
        STAT_FULL      = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_FIRST,
        S_PROBE,
        S_RESULT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic clear_wr;
        logic load_item;
        logic div_step;
        logic probe_first;
        logic probe_eval;
        logic out_load;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
        logic div_last;
        logic probe_done;
        logic out_free;
    } ctrl_sts_t;

endpackage

// ===== sv/htlp_ram.sv =====
// generic simple dual-port ram: one write port, one registered read port
// no dependencies
module htlp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/htlp_ctrl.sv =====
// controller fsm of the hash table: clearing pass, remainder, probe walk,
// hand-off to the output register
// depends on htlp_pkg
module htlp_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                in_ready,
    input  htlp_pkg::ctrl_sts_t sts,
    output htlp_pkg::ctrl_cmd_t cmd
);

    import htlp_pkg::*;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (sts.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (sts.div_last)
                begin
                    state_next = S_FIRST;
                end
            end
            S_FIRST:
            begin
                state_next = S_PROBE;
            end
            S_PROBE:
            begin
                if (sts.probe_done)
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
            end
            S_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.load_item = s_tvalid;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            S_FIRST:
            begin
                cmd.probe_first = 1'b1;
            end
            S_PROBE:
            begin
                cmd.probe_eval = 1'b1;
            end
            S_RESULT:
            begin
                cmd.out_load = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== sv/htlp_dp.sv =====
// datapath of the hash table: config register, key remainder unit, probe
// pointer, table ram and output register
// depends on htlp_pkg and htlp_ram
module htlp_dp #(
    parameter int TABLE_DEPTH = htlp_pkg::TABLE_DEPTH_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // config write
    input  logic                            cfg_valid,
    input  logic [htlp_pkg::CFG_W-1:0]      cfg_data,
    // input beat fields
    input  logic                            in_cmd,
    input  logic [htlp_pkg::KEY_W-1:0]      in_key,
    input  logic [htlp_pkg::PAYLOAD_W-1:0]  in_payload,
    // output register
    input  logic                            out_ready,
    output logic                            out_valid,
    output logic [htlp_pkg::STATUS_W-1:0]   out_status,
    output logic [htlp_pkg::SLOT_W-1:0]     out_slot,
    output logic [htlp_pkg::PAYLOAD_W-1:0]  out_found,
    output logic [htlp_pkg::PROBES_W-1:0]   out_probes,
    // controller link
    input  htlp_pkg::ctrl_cmd_t             cmd,
    output htlp_pkg::ctrl_sts_t             sts
);

    import htlp_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int MW    = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    // config and clearing pass
    logic [CFG_W-1:0]     cfg_reg;
    logic [IDX_W-1:0]     clr_reg;
    logic [MW-1:0]        cfg_ext;
    logic [MW-1:0]        mod_clamp;
    logic [CNT_W-1:0]     mod_eff;

    // item and remainder unit
    cmd_t                 cmd_reg;
    logic [KEY_W-1:0]     key_reg;
    logic [PAYLOAD_W-1:0] payload_reg;
    logic [KEY_W-1:0]     key_sh_reg;
    logic [CNT_W-1:0]     rem_reg;
    logic [CNT_W-1:0]     rem_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg;

    // probe walk
    logic [IDX_W-1:0]     home_reg;
    logic [IDX_W-1:0]     pos_reg;
    logic [IDX_W-1:0]     pos_inc;
    logic [CNT_W-1:0]     pos_plus;
    logic [CNT_W-1:0]     n_reg;

    // table ram
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [ENTRY_W-1:0]   ram_wdata;
    logic                 ram_re;
    logic [IDX_W-1:0]     ram_raddr;
    logic [ENTRY_W-1:0]   ram_rdata;
    logic                 ent_occ;
    logic [KEY_W-1:0]     ent_key;
    logic [PAYLOAD_W-1:0] ent_payload;

    // probe decision
    logic                 key_hit;
    logic                 walk_end;
    logic                 probe_done;
    status_t              res_status;
    logic [IDX_W-1:0]     res_slot;
    logic [PAYLOAD_W-1:0] res_found;

    // result and output registers
    status_t              res_status_reg;
    logic [IDX_W-1:0]     res_slot_reg;
    logic [PAYLOAD_W-1:0] res_found_reg;
    logic [CNT_W-1:0]     res_probes_reg;
    logic                 out_valid_reg;
    status_t              out_status_reg;
    logic [SLOT_W-1:0]    out_slot_reg;
    logic [PAYLOAD_W-1:0] out_found_reg;
    logic [PROBES_W-1:0]  out_probes_reg;

    // effective modulus, clamped to 2..TABLE_DEPTH
    always_comb
    begin
        cfg_ext = MW'(cfg_reg);
        priority if (cfg_ext < MW'(2))
        begin
            mod_clamp = MW'(2);
        end
        else if (cfg_ext > MW'(TABLE_DEPTH))
        begin
            mod_clamp = MW'(TABLE_DEPTH);
        end
        else
        begin
            mod_clamp = cfg_ext;
        end
        mod_eff = CNT_W'(mod_clamp);
    end

    // config register and clearing counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= MODULUS_RESET;
            clr_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                cfg_reg <= cfg_data;
            end
            if (cmd.clear_wr)
            begin
                clr_reg <= clr_reg + IDX_W'(1);
            end
        end
    end

    // remainder unit: restoring steps, key bits msb first
    always_comb
    begin
        logic [CNT_W:0]   trial;
        logic [CNT_W-1:0] r;
        r = rem_reg;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            trial = {r, key_sh_reg[KEY_W-1-i]};
            if (trial >= {1'b0, mod_eff})
            begin
                r = CNT_W'(trial - {1'b0, mod_eff});
            end
            else
            begin
                r = CNT_W'(trial);
            end
        end
        rem_next = r;
    end

    // next probe position with wrap to slot 0
    always_comb
    begin
        pos_plus = CNT_W'(pos_reg) + CNT_W'(1);
        if (pos_plus >= mod_eff)
        begin
            pos_inc = '0;
        end
        else
        begin
            pos_inc = IDX_W'(pos_plus);
        end
    end

    // entry fields and probe decision
    assign ent_occ     = ram_rdata[ENTRY_W-1];
    assign ent_key     = ram_rdata[ENTRY_W-2 -: KEY_W];
    assign ent_payload = ram_rdata[PAYLOAD_W-1:0];
    assign key_hit     = ent_occ && (cmd_reg == CMD_SEARCH) && (ent_key == key_reg);
    assign walk_end    = (n_reg == mod_eff);
    assign probe_done  = !ent_occ || key_hit || walk_end;

    always_comb
    begin
        res_found = '0;
        priority if (!ent_occ)
        begin
            if (cmd_reg == CMD_INSERT)
            begin
                res_status = STAT_INSERTED;
                res_slot   = pos_reg;
            end
            else
            begin
                res_status = STAT_NOT_FOUND;
                res_slot   = home_reg;
            end
        end
        else if (key_hit)
        begin
            res_status = STAT_FOUND;
            res_slot   = pos_reg;
            res_found  = ent_payload;
        end
        else
        begin
            res_status = (cmd_reg == CMD_INSERT) ? STAT_FULL : STAT_NOT_FOUND;
            res_slot   = home_reg;
        end
    end

    // item, remainder and probe registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg <= '0;
        end
        else if (cmd.load_item)
        begin
            div_cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            cmd_reg     <= cmd_t'(in_cmd);
            key_reg     <= in_key;
            payload_reg <= in_payload;
            key_sh_reg  <= in_key;
            rem_reg     <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg    <= rem_next;
            key_sh_reg <= key_sh_reg << DIV_BITS;
        end
        if (cmd.probe_first)
        begin
            home_reg <= IDX_W'(rem_reg);
            pos_reg  <= IDX_W'(rem_reg);
            n_reg    <= CNT_W'(1);
        end
        if (cmd.probe_eval && !probe_done)
        begin
            pos_reg <= pos_inc;
            n_reg   <= n_reg + CNT_W'(1);
        end
        if (cmd.probe_eval && probe_done)
        begin
            res_status_reg <= res_status;
            res_slot_reg   <= res_slot;
            res_found_reg  <= res_found;
            res_probes_reg <= n_reg;
        end
    end

    // ram ports: clearing writes, insert into a free slot, probe reads
    assign ram_we    = cmd.clear_wr || (cmd.probe_eval && !ent_occ && (cmd_reg == CMD_INSERT));
    assign ram_waddr = cmd.clear_wr ? clr_reg : pos_reg;
    assign ram_wdata = cmd.clear_wr ? '0 : {1'b1, key_reg, payload_reg};
    assign ram_re    = cmd.probe_first || (cmd.probe_eval && !probe_done);
    assign ram_raddr = cmd.probe_first ? IDX_W'(rem_reg) : pos_inc;

    htlp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_slot_reg   <= SLOT_W'(res_slot_reg);
            out_found_reg  <= res_found_reg;
            out_probes_reg <= PROBES_W'(res_probes_reg);
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_slot   = out_slot_reg;
    assign out_found  = out_found_reg;
    assign out_probes = out_probes_reg;

    // status to controller
    assign sts.clear_last = (clr_reg == IDX_W'(TABLE_DEPTH - 1));
    assign sts.div_last   = (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
    assign sts.probe_done = probe_done;
    assign sts.out_free   = !out_valid_reg || out_ready;

endmodule

// ===== sv/hash_table_linear_probing_top.sv =====
// top level of the linear-probing hash table: stream ports, config port
// depends on htlp_pkg, htlp_ctrl, htlp_dp (and htlp_ram below it)
//
//  channel   handshake            contents
//  --------  -------------------  -----------------------------------------
//  s_*       s_tvalid / s_tready  tuser: cmd; tdata: key, payload
//  m_*       m_tvalid / m_tready  tuser: status; tdata: slot, found, probes
//  cfg_*     cfg_valid/cfg_ready  cfg_data: table_modulus
//
// an item goes from the accepting beat through the 2-bit-per-cycle remainder
// unit and then the probe walk, one ram read per probe on the single table
// ram read port, to a loaded result
// after reset a clearing pass writes every slot with s_tready low; config
// beats are taken throughout
// one finished result waits in the output register while the next item is
// accepted and worked on; that item's result waits until the register frees
module hash_table_linear_probing_top #(
    parameter int TABLE_DEPTH = htlp_pkg::TABLE_DEPTH_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [htlp_pkg::S_TDATA_W-1:0]  s_tdata,   // key[29:0], payload[61:30], zero
    input  logic                            s_tuser,   // cmd[0]
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [htlp_pkg::M_TDATA_W-1:0]  m_tdata,   // slot[9:0], found_payload[41:10],
                                                       // probes[52:42], zero
    output logic [htlp_pkg::STATUS_W-1:0]   m_tuser,   // status[1:0]
    // config write
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [htlp_pkg::CFG_W-1:0]      cfg_data
);

    import htlp_pkg::*;

    ctrl_cmd_t            cmd;
    ctrl_sts_t            sts;
    logic [SLOT_W-1:0]    out_slot;
    logic [PAYLOAD_W-1:0] out_found;
    logic [PROBES_W-1:0]  out_probes;

    // config register always takes a beat
    assign cfg_ready = 1'b1;

    htlp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    htlp_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .in_cmd     (s_tuser),
        .in_key     (s_tdata[KEY_W-1:0]),
        .in_payload (s_tdata[KEY_W +: PAYLOAD_W]),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_status (m_tuser),
        .out_slot   (out_slot),
        .out_found  (out_found),
        .out_probes (out_probes),
        .cmd        (cmd),
        .sts        (sts)
    );

    // result beat packing
    assign m_tdata = {{M_PAD_W{1'b0}}, out_probes, out_found, out_slot};

endmodule

// ===== tb/hash_table_checker.sv =====
// checker for the linear-probing hash table: watches the input, result and
// config channels, keeps its own copy of the table and compares every result
// depends on htlp_pkg
module hash_table_checker #(
    parameter int DEPTH = htlp_pkg::TABLE_DEPTH_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [htlp_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                            s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [htlp_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic [htlp_pkg::STATUS_W-1:0]   m_tuser,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [htlp_pkg::CFG_W-1:0]      cfg_data,
    output int                              fail_count,
    output int                              pending_count,
    output int                              checked_count
);

    import htlp_pkg::*;

    // one predicted result beat
    typedef struct packed {
        status_t                status;
        logic [SLOT_W-1:0]      slot;
        logic [PAYLOAD_W-1:0]   found_payload;
        logic [PROBES_W-1:0]    probes;
    } table_outcome_t;

    // shadow copy of the table and its size register
    bit                     slot_used [DEPTH];
    bit [KEY_W-1:0]         key_store [DEPTH];
    bit [PAYLOAD_W-1:0]     payload_store [DEPTH];
    logic [CFG_W-1:0]       modulus_reg;
    table_outcome_t         outcome_q [$];

    // probe walk for one command; an insert updates the shadow table
    function automatic table_outcome_t walk_table(cmd_t cmd, logic [KEY_W-1:0] key,
                                                  logic [PAYLOAD_W-1:0] payload);
        int unsigned    m;
        int unsigned    home;
        int unsigned    pos;
        int unsigned    n;
        bit             done;
        table_outcome_t r;

        m = modulus_reg;
        if (m < 2)
        begin
            m = 2;
        end
        if (m > DEPTH)
        begin
            m = DEPTH;
        end
        home = key % m;
        pos = home;
        done = 1'b0;
        r.status = (cmd == CMD_INSERT) ? STAT_FULL : STAT_NOT_FOUND;
        r.slot = SLOT_W'(home);
        r.found_payload = '0;
        r.probes = PROBES_W'(m);

        for (n = 1; n <= m && !done; n++)
        begin
            if (!slot_used[pos])
            begin
                // free slot: insert lands here, search stops here
                if (cmd == CMD_INSERT)
                begin
                    slot_used[pos] = 1'b1;
                    key_store[pos] = key;
                    payload_store[pos] = payload;
                    r.status = STAT_INSERTED;
                    r.slot = SLOT_W'(pos);
                end
                r.probes = PROBES_W'(n);
                done = 1'b1;
            end
            else if (cmd == CMD_SEARCH && key_store[pos] == key)
            begin
                r.status = STAT_FOUND;
                r.slot = SLOT_W'(pos);
                r.found_payload = payload_store[pos];
                r.probes = PROBES_W'(n);
                done = 1'b1;
            end
            // wrap to slot 0 at the end of the slots in use
            pos = (pos + 1 >= m) ? 0 : pos + 1;
        end
        return r;
    endfunction

    // channel monitor
    always @(posedge clk or negedge rst_n)
    begin
        table_outcome_t want;
        logic [SLOT_W-1:0]      got_slot;
        logic [PAYLOAD_W-1:0]   got_payload;
        logic [PROBES_W-1:0]    got_probes;
        int                     i;

        if (!rst_n)
        begin
            for (i = 0; i < DEPTH; i++)
            begin
                slot_used[i] = 1'b0;
            end
            modulus_reg = MODULUS_RESET;
            outcome_q.delete();
            fail_count = 0;
            pending_count = 0;
            checked_count = 0;
        end
        else
        begin
            // result beat against the oldest prediction
            if (m_tvalid && m_tready)
            begin
                if (outcome_q.size() == 0)
                begin
                    $error("result beat with no command outstanding");
                    fail_count++;
                end
                else
                begin
                    want = outcome_q.pop_front();
                    got_slot = m_tdata[SLOT_W-1:0];
                    got_payload = m_tdata[SLOT_W +: PAYLOAD_W];
                    got_probes = m_tdata[SLOT_W+PAYLOAD_W +: PROBES_W];
                    if (m_tuser !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, m_tuser);
                        fail_count++;
                    end
                    if (got_slot !== want.slot)
                    begin
                        $error("slot: expected %0d, got %0d", want.slot, got_slot);
                        fail_count++;
                    end
                    if (got_payload !== want.found_payload)
                    begin
                        $error("found_payload: expected %h, got %h",
                               want.found_payload, got_payload);
                        fail_count++;
                    end
                    if (got_probes !== want.probes)
                    begin
                        $error("probes: expected %0d, got %0d", want.probes, got_probes);
                        fail_count++;
                    end
                    checked_count++;
                end
            end

            // table size write
            if (cfg_valid && cfg_ready)
            begin
                modulus_reg = cfg_data;
            end

            // command beat
            if (s_tvalid && s_tready)
            begin
                outcome_q.push_back(walk_table(cmd_t'(s_tuser), s_tdata[KEY_W-1:0],
                                               s_tdata[KEY_W +: PAYLOAD_W]));
            end
            pending_count = outcome_q.size();
        end
    end

endmodule

// ===== tb/hash_table_linear_probing_top_test.sv =====
// testbench top for the linear-probing hash table: clock, reset, directed and
// random insert/search traffic over several table sizes, random stalls
// depends on htlp_pkg, hash_table_linear_probing_top, hash_table_checker
module hash_table_linear_probing_top_test;

    import htlp_pkg::*;

    localparam logic [KEY_W-1:0] MAX_KEY   = 30'd999999999;
    localparam int          DRAIN_CYCLES = 40;
    localparam int          PHASES       = 10;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [STATUS_W-1:0]    m_tuser;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_W-1:0]       cfg_data;

    int                     fail_count;
    int                     pending_count;
    int                     checked_count;

    int                     insert_count;
    int                     search_count;
    int                     size_count;
    int                     rx_cycle;
    int unsigned            stall_left;
    bit                     rx_steady;
    bit                     tx_steady;
    logic [KEY_W-1:0]       inserted_keys [$];
    int unsigned            phase_mod [PHASES];
    int unsigned            phase_items [PHASES];

    hash_table_linear_probing_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    hash_table_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .pending_count  (pending_count),
        .checked_count  (checked_count)
    );

    // clock, period 8
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // idle length: mostly short, a few long
    function automatic int unsigned idle_len();
        int unsigned r;

        r = $urandom_range(99, 0);
        if (r < 45)
        begin
            return 0;
        end
        if (r < 85)
        begin
            return $urandom_range(3, 1);
        end
        if (r < 97)
        begin
            return $urandom_range(12, 4);
        end
        return $urandom_range(60, 20);
    endfunction

    // result side back-pressure, with stall-free stretches
    always @(negedge clk)
    begin
        rx_cycle++;
        if (rx_cycle % 256 == 0)
        begin
            rx_steady = ($urandom_range(3, 0) == 0);
        end
        if (stall_left != 0)
        begin
            m_tready = 1'b0;
            stall_left--;
        end
        else
        begin
            m_tready = 1'b1;
            if (!rx_steady && $urandom_range(3, 0) == 0)
            begin
                stall_left = idle_len();
            end
        end
    end

    // one command beat, driven at the falling edge
    task automatic send_command(cmd_t cmd, logic [KEY_W-1:0] key, logic [PAYLOAD_W-1:0] payload);
        int unsigned gap;

        gap = tx_steady ? 0 : idle_len();
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser = cmd;
        s_tdata = {{(S_TDATA_W-KEY_W-PAYLOAD_W){1'b0}}, payload, key};
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
        if (cmd == CMD_INSERT)
        begin
            insert_count++;
            inserted_keys.push_back(key);
        end
        else
        begin
            search_count++;
        end
    endtask

    // table size write, only while the block is idle
    task automatic write_modulus(logic [CFG_W-1:0] value);
        s_tvalid = 1'b0;
        cfg_valid = 1'b1;
        cfg_data = value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
        size_count++;
    endtask

    // wait until every predicted result has come back
    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (pending_count != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // key that is random, clustered on a few home slots, or at the range ends
    function automatic logic [KEY_W-1:0] fresh_key(int unsigned m);
        int unsigned r;

        r = $urandom_range(9, 0);
        if (r < 5)
        begin
            return KEY_W'($urandom_range(MAX_KEY, 0));
        end
        if (r < 9)
        begin
            return KEY_W'(m * $urandom_range(MAX_KEY / m - 1, 0) + $urandom_range(3, 0));
        end
        return KEY_W'(($urandom_range(1, 0) != 0) ? MAX_KEY : $urandom_range(3, 0));
    endfunction

    // stimulus and verdict
    initial
    begin
        int             p;
        int             k;
        int unsigned    c;
        int unsigned    m;
        logic [KEY_W-1:0] key;

        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tuser = CMD_INSERT;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        stall_left = 0;
        rx_steady = 1'b0;
        tx_steady = 1'b0;
        rx_cycle = 0;
        insert_count = 0;
        search_count = 0;
        size_count = 0;
        phase_mod = '{2, 3, 7, 13, 31, 67, 101, 257, 631, 1024};
        phase_items = '{100, 100, 150, 150, 200, 150, 150, 100, 80, 70};

        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // size below range acts as 2: fill both slots, then overflow
        write_modulus(11'd0);
        send_command(CMD_INSERT, 30'd0, 32'h0000_0000);
        send_command(CMD_INSERT, MAX_KEY, 32'hFFFF_FFFF);
        send_command(CMD_INSERT, 30'd4, 32'h1234_5678);
        send_command(CMD_SEARCH, MAX_KEY, 32'hDEAD_BEEF);
        send_command(CMD_SEARCH, 30'd0, 32'hFFFF_FFFF);
        send_command(CMD_SEARCH, 30'd6, 32'h0000_0000);
        wait_drained();

        // size above depth acts as depth; old slots stay filled, duplicates
        write_modulus(11'd2047);
        send_command(CMD_INSERT, 30'd1024, 32'hA5A5_5A5A);
        send_command(CMD_INSERT, 30'd1024, 32'h5A5A_A5A5);
        send_command(CMD_SEARCH, 30'd1024, 32'h0);
        send_command(CMD_SEARCH, 30'd2048, 32'h0);
        send_command(CMD_INSERT, 30'd1023, 32'hFFFF_0000);
        send_command(CMD_INSERT, 30'd2047, 32'h0000_FFFF);
        send_command(CMD_SEARCH, 30'd0, 32'h0);
        send_command(CMD_SEARCH, 30'd2047, 32'h0);
        wait_drained();

        // shrink back over a filled table: wrap inside the slots in use only
        write_modulus(11'd1);
        send_command(CMD_SEARCH, MAX_KEY, 32'h0);
        send_command(CMD_SEARCH, 30'd5, 32'h0);
        send_command(CMD_INSERT, 30'd7, 32'h8000_0001);
        wait_drained();
        write_modulus(11'd3);
        send_command(CMD_SEARCH, 30'd1024, 32'h0);
        send_command(CMD_SEARCH, 30'd2047, 32'h0);
        wait_drained();

        // random traffic, one table size per phase, small sizes first
        for (p = 0; p < PHASES; p++)
        begin
            m = phase_mod[p];
            write_modulus(CFG_W'(m));
            for (k = 0; k < phase_items[p]; k++)
            begin
                if (k % 40 == 0)
                begin
                    tx_steady = ($urandom_range(3, 0) == 0);
                end
                c = $urandom_range(99, 0);
                if (c < 45)
                begin
                    send_command(CMD_INSERT, fresh_key(m), $urandom());
                end
                else if (c < 80 && inserted_keys.size() != 0)
                begin
                    key = inserted_keys[$urandom_range(inserted_keys.size() - 1, 0)];
                    send_command(CMD_SEARCH, key, $urandom());
                end
                else
                begin
                    send_command(CMD_SEARCH, fresh_key(m), $urandom());
                end
            end
            wait_drained();
        end

        $display("covered %0d inserts and %0d searches over %0d table size settings,",
                 insert_count, search_count, size_count);
        $display("%0d result beats compared, %0d mismatches", checked_count, fail_count);
        if (fail_count == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // run limit, several times the slowest legal run
    initial
    begin
        #80000000;
        $display("run limit reached with %0d results outstanding", pending_count);
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== hash_table_linear_probing_top.f =====
sv/htlp_pkg.sv
sv/htlp_ram.sv
sv/htlp_ctrl.sv
sv/htlp_dp.sv
sv/hash_table_linear_probing_top.sv
tb/hash_table_checker.sv
tb/hash_table_linear_probing_top_test.sv
